// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the controller of the led bar graph serializer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/lbgs_pkg.sv -----
// types, constants and bar fill functions for the led bar graph serializer
`timescale 1ns / 1ps

package lbgs_pkg;

    localparam int WORD_BITS  = 16;
    localparam int FRAME_BITS = 64;
    localparam int POS_BITS   = $clog2(FRAME_BITS);

    localparam logic [1:0] CMD_BATTERY = 2'd0;
    localparam logic [1:0] CMD_TEMP    = 2'd1;
    localparam logic [1:0] CMD_FAULT   = 2'd2;

    localparam logic [WORD_BITS-1:0] FAULT_LOW_SET  = 16'h0003;
    localparam logic [WORD_BITS-1:0] FAULT_HIGH_SET = 16'hC000;
    localparam logic [WORD_BITS-1:0] FAULT_LOW_CLR  = 16'hFFFC;
    localparam logic [WORD_BITS-1:0] FAULT_HIGH_CLR = 16'h3FFF;
    localparam logic [8:0]           TEMP_OFFSET    = 9'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] level;
        logic       fault_on;
    } event_t;

    typedef struct packed {
        logic                data_bit;
        logic [POS_BITS-1:0] bit_position;
        logic                last_bit;
    } led_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic clear_count;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic changed;
        logic at_last;
    } ctrl_status_t;

    // n lit leds from the msb, saturating at a full word
    function automatic logic [WORD_BITS-1:0] bar_fill(input logic [8:0] n);
        logic [WORD_BITS-1:0] fill;
        if (n == 9'd0)
        begin
            fill = '0;
        end
        else if (n >= 9'(WORD_BITS))
        begin
            fill = '1;
        end
        else
        begin
            fill = ~({WORD_BITS{1'b1}} >> n[3:0]);
        end
        return fill;
    endfunction

    // second word of a bar that spans two words
    function automatic logic [WORD_BITS-1:0] bar_fill_upper(input logic [8:0] n);
        logic [WORD_BITS-1:0] fill;
        if (n >= 9'(WORD_BITS))
        begin
            fill = bar_fill(n - 9'(WORD_BITS));
        end
        else
        begin
            fill = '0;
        end
        return fill;
    endfunction

endpackage

// ----- rtl/core/led_bar_graph_serializer_unit.sv -----
// top level of the led bar graph serializer
`timescale 1ns / 1ps

// event channel: event_valid / event_stall with event_data (command, level,
// fault_on). an item is taken when event_valid is high and event_stall low.
// led channel: led_valid / led_stall with led_data (data_bit, bit_position,
// last_bit), one item per shift clock of the led chain.
// an item that changes the battery, temperature or fault reading updates the
// 64-bit frame and sends it out as 64 items, word 0 first, lsb first, with
// last_bit on bit 63 so the latch can pulse after it. an item that repeats
// the stored reading, or carries an unknown command, sends nothing.
// sequence: the item is taken in the idle state, the frame is updated in
// the update state, then one bit per cycle is shifted out while led_stall
// is low; an item that sends nothing returns to idle after the update.
// event_stall stays high until the frame has gone out.
// reset clears the frame and the stored readings to zero and leaves the
// block idle. a stall on the led channel holds the current bit in place.

module led_bar_graph_serializer_unit
    import lbgs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   event_valid,
    output logic   event_stall,
    input  event_t event_data,
    output logic   led_valid,
    input  logic   led_stall,
    output led_t   led_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    lbgs_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .led_stall   (led_stall),
        .status      (status),
        .cmd         (cmd),
        .event_stall (event_stall),
        .led_valid   (led_valid)
    );

    lbgs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .event_data (event_data),
        .cmd        (cmd),
        .status     (status),
        .led_data   (led_data)
    );

endmodule

// ----- rtl/core/lbgs_datapath.sv -----
// frame store, stored readings and bit counter of the serializer
`timescale 1ns / 1ps

module lbgs_datapath
    import lbgs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  event_t       event_data,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    output led_t         led_data
);

    event_t                  item_reg;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [7:0]              battery_reg, battery_next;
    logic [7:0]              temp_reg, temp_next;
    logic                    fault_reg, fault_next;
    logic [POS_BITS-1:0]     count_reg;

    logic [8:0]              temp_n;
    logic [WORD_BITS-1:0]    bat_upper;
    logic [WORD_BITS-1:0]    temp_lower;
    logic                    changed;

    // item is captured on acceptance and used in the update cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= event_data;
        end
    end

    always_comb
    begin
        temp_n     = {1'b0, item_reg.level} + TEMP_OFFSET;
        bat_upper  = bar_fill_upper({1'b0, item_reg.level});
        bat_upper  = fault_reg ? (bat_upper | FAULT_LOW_SET) : (bat_upper & FAULT_LOW_CLR);
        temp_lower = bar_fill(temp_n);
        temp_lower = fault_reg ? (temp_lower | FAULT_HIGH_SET)
                               : (temp_lower & FAULT_HIGH_CLR);

        frame_next   = frame_reg;
        battery_next = battery_reg;
        temp_next    = temp_reg;
        fault_next   = fault_reg;
        changed      = 1'b0;

        unique case (item_reg.command)
            CMD_BATTERY:
            begin
                changed = (item_reg.level != battery_reg);
                battery_next = item_reg.level;
                frame_next[WORD_BITS-1:0]           = bar_fill({1'b0, item_reg.level});
                frame_next[2*WORD_BITS-1:WORD_BITS] = bat_upper;
            end
            CMD_TEMP:
            begin
                changed = (item_reg.level != temp_reg);
                temp_next = item_reg.level;
                frame_next[3*WORD_BITS-1:2*WORD_BITS] = temp_lower;
                frame_next[4*WORD_BITS-1:3*WORD_BITS] = bar_fill_upper(temp_n);
            end
            CMD_FAULT:
            begin
                changed = (item_reg.fault_on != fault_reg);
                fault_next = item_reg.fault_on;
                if (item_reg.fault_on)
                begin
                    frame_next[2*WORD_BITS-1:WORD_BITS] =
                        frame_reg[2*WORD_BITS-1:WORD_BITS] | FAULT_LOW_SET;
                    frame_next[3*WORD_BITS-1:2*WORD_BITS] =
                        frame_reg[3*WORD_BITS-1:2*WORD_BITS] | FAULT_HIGH_SET;
                end
                else
                begin
                    frame_next[2*WORD_BITS-1:WORD_BITS] =
                        frame_reg[2*WORD_BITS-1:WORD_BITS] & FAULT_LOW_CLR;
                    frame_next[3*WORD_BITS-1:2*WORD_BITS] =
                        frame_reg[3*WORD_BITS-1:2*WORD_BITS] & FAULT_HIGH_CLR;
                end
            end
            default:
            begin
                changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            battery_reg <= '0;
            temp_reg    <= '0;
            fault_reg   <= 1'b0;
        end
        else if (cmd.update && changed)
        begin
            frame_reg   <= frame_next;
            battery_reg <= battery_next;
            temp_reg    <= temp_next;
            fault_reg   <= fault_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear_count)
        begin
            count_reg <= '0;
        end
        else if (cmd.advance)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign status.changed = changed;
    assign status.at_last = (count_reg == POS_BITS'(FRAME_BITS - 1));

    assign led_data.data_bit     = frame_reg[count_reg];
    assign led_data.bit_position = count_reg;
    assign led_data.last_bit     = status.at_last;

endmodule

// ----- rtl/core/lbgs_controller.sv -----
// sequencing of capture, frame update and bit shifting
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lbgs_controller
    import lbgs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         event_valid,
    input  logic         led_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic         event_stall,
    output logic         led_valid
);

    state_t state_reg, state_next;
    logic   in_shift;
    logic   in_update;
    logic   last_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        event_stall = 1'b1;
        led_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                event_stall = 1'b0;
                cmd.load    = event_valid;
                if (event_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update      = 1'b1;
                cmd.clear_count = 1'b1;
                // an unchanged reading sends no frame
                state_next = status.changed ? ST_SHIFT : ST_IDLE;
            end
            ST_SHIFT:
            begin
                led_valid = 1'b1;
                if (!led_stall)
                begin
                    cmd.advance = 1'b1;
                    if (status.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_shift   = (state_reg == ST_SHIFT);
    assign in_update  = (state_reg == ST_UPDATE);
    assign last_taken = in_shift && !led_stall && status.at_last;

    `ASSERT_NEXT(a_shift_holds_on_stall, in_shift && led_stall, in_shift, "shift left on stall")
    `ASSERT_NEXT(a_idle_after_last, last_taken, state_reg == ST_IDLE, "no idle after last bit")
    `ASSERT_NEXT(a_update_one_cycle, in_update, !in_update, "update over one cycle")
    `ASSERT_IMPL(a_no_advance_when_stalled, led_stall, !cmd.advance, "counter moved on stall")

endmodule

// ----- tb/led_bar_graph_serializer_unit_test.sv -----
// testbench for the led bar graph serializer: directed, random and back-pressure items
`timescale 1ns / 1ps

module led_bar_graph_serializer_unit_test;
    import lbgs_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         TAIL_CYCLES = 80;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   event_valid = 1'b0;
    logic   event_stall;
    event_t event_data  = '0;
    logic   led_valid;
    logic   led_stall   = 1'b0;
    led_t   led_data;

    // shadow of the frame and the stored readings
    logic [WORD_BITS-1:0] frame_word [4];
    logic [7:0]           battery_level;
    logic [7:0]           temp_level;
    logic                 fault_lit;

    led_t expected_bits [$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_request  = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;
    int   items_sent    = 0;
    int   frames_due    = 0;
    int   bits_checked  = 0;

    led_bar_graph_serializer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_data  (event_data),
        .led_valid   (led_valid),
        .led_stall   (led_stall),
        .led_data    (led_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("led_bar_graph_serializer_unit_test NOT OK");
        $finish;
    end

    // n lit leds from the top bit, none for n <= 0, full word from 16 up
    function automatic logic [WORD_BITS-1:0] lit_leds(input int n);
        logic [WORD_BITS-1:0] leds;
        if (n <= 0)
        begin
            leds = '0;
        end
        else if (n >= WORD_BITS)
        begin
            leds = '1;
        end
        else
        begin
            leds = 16'hFFFF << (WORD_BITS - n);
        end
        return leds;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // updates the shadow frame and queues the 64 bits a changed reading sends
    task automatic predict_frame(input event_t ev, output int produced);
        int   bar;
        led_t bit_item;
        produced = 0;
        case (ev.command)
            CMD_BATTERY:
            begin
                if (ev.level != battery_level)
                begin
                    battery_level = ev.level;
                    bar = int'(ev.level);
                    frame_word[0] = lit_leds(bar);
                    frame_word[1] = lit_leds(bar - WORD_BITS);
                    frame_word[1][1:0] = {2{fault_lit}};
                    produced = FRAME_BITS;
                end
            end
            CMD_TEMP:
            begin
                if (ev.level != temp_level)
                begin
                    temp_level = ev.level;
                    bar = int'(ev.level) + 2;
                    frame_word[2] = lit_leds(bar);
                    frame_word[2][15:14] = {2{fault_lit}};
                    frame_word[3] = lit_leds(bar - WORD_BITS);
                    produced = FRAME_BITS;
                end
            end
            CMD_FAULT:
            begin
                if (ev.fault_on != fault_lit)
                begin
                    fault_lit = ev.fault_on;
                    frame_word[1][1:0] = {2{fault_lit}};
                    frame_word[2][15:14] = {2{fault_lit}};
                    produced = FRAME_BITS;
                end
            end
            default:
            begin
            end
        endcase
        if (produced > 0)
        begin
            frames_due++;
            for (int k = 0; k < FRAME_BITS; k++)
            begin
                bit_item.data_bit     = frame_word[k / WORD_BITS][k % WORD_BITS];
                bit_item.bit_position = 6'(k);
                bit_item.last_bit     = (k == FRAME_BITS - 1);
                expected_bits.push_back(bit_item);
            end
        end
    endtask

    // offers one item after idle cycles drawn one at a time, predicts it once taken
    task automatic send_event(input event_t ev, output int produced);
        while ($urandom_range(99) < send_idle_pct)
        begin
            event_valid <= 1'b0;
            @(posedge clk);
        end
        event_valid <= 1'b1;
        event_data  <= ev;
        do
            @(posedge clk);
        while (event_stall !== 1'b0);
        items_sent++;
        predict_frame(ev, produced);
    endtask

    task automatic apply(input logic [1:0] cmd, input logic [7:0] lvl, input logic flt);
        event_t ev;
        int     produced;
        ev.command  = cmd;
        ev.level    = lvl;
        ev.fault_on = flt;
        send_event(ev, produced);
    endtask

    function automatic event_t random_event();
        event_t ev;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            ev.command = CMD_BATTERY;
        end
        else if (pick < 80)
        begin
            ev.command = CMD_TEMP;
        end
        else if (pick < 95)
        begin
            ev.command = CMD_FAULT;
        end
        else
        begin
            ev.command = CMD_UNUSED;
        end
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            ev.level = 8'($urandom_range(0, 40));
        end
        else if (pick < 60)
        begin
            // word and saturation edges of both bars
            case ($urandom_range(0, 7))
                0:       ev.level = 8'd0;
                1:       ev.level = 8'd13;
                2:       ev.level = 8'd14;
                3:       ev.level = 8'd15;
                4:       ev.level = 8'd16;
                5:       ev.level = 8'd30;
                6:       ev.level = 8'd32;
                default: ev.level = 8'd255;
            endcase
        end
        else
        begin
            ev.level = 8'($urandom_range(0, 255));
        end
        ev.fault_on = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            led_stall <= 1'b1;
        end
        else
        begin
            led_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        led_t want;
        if (rst_n && led_valid === 1'b1 && led_stall === 1'b0)
        begin
            if (expected_bits.size() == 0)
            begin
                report_mismatch("unexpected led item at position",
                                int'(led_data.bit_position), -1);
            end
            else
            begin
                want = expected_bits.pop_front();
                if (led_data.data_bit !== want.data_bit)
                begin
                    report_mismatch($sformatf("data_bit at position %0d", want.bit_position),
                                    int'(led_data.data_bit), int'(want.data_bit));
                end
                if (led_data.bit_position !== want.bit_position)
                begin
                    report_mismatch("bit_position", int'(led_data.bit_position),
                                    int'(want.bit_position));
                end
                if (led_data.last_bit !== want.last_bit)
                begin
                    report_mismatch($sformatf("last_bit at position %0d", want.bit_position),
                                    int'(led_data.last_bit), int'(want.last_bit));
                end
                bits_checked++;
            end
        end
    end

    task automatic test_directed();
        apply(CMD_BATTERY, 8'd0, 1'b0);     // same as reset value, nothing sent
        apply(CMD_BATTERY, 8'd13, 1'b0);
        apply(CMD_BATTERY, 8'd16, 1'b0);
        apply(CMD_BATTERY, 8'd17, 1'b1);
        apply(CMD_BATTERY, 8'd255, 1'b0);
        apply(CMD_BATTERY, 8'd255, 1'b0);   // repeat
        apply(CMD_BATTERY, 8'd1, 1'b0);
        apply(CMD_BATTERY, 8'd15, 1'b0);
        apply(CMD_BATTERY, 8'd32, 1'b0);
        apply(CMD_TEMP, 8'd0, 1'b1);        // repeat of reset value
        apply(CMD_TEMP, 8'd13, 1'b0);
        apply(CMD_TEMP, 8'd14, 1'b0);
        apply(CMD_TEMP, 8'd30, 1'b0);
        apply(CMD_TEMP, 8'd255, 1'b0);      // offset carries past 8 bits
        apply(CMD_TEMP, 8'd254, 1'b0);
        apply(CMD_FAULT, 8'd170, 1'b1);
        apply(CMD_FAULT, 8'd85, 1'b1);      // repeat
        apply(CMD_BATTERY, 8'd31, 1'b0);
        apply(CMD_TEMP, 8'd7, 1'b0);
        apply(CMD_UNUSED, 8'd255, 1'b1);
        apply(CMD_FAULT, 8'd0, 1'b0);
        apply(CMD_BATTERY, 8'd0, 1'b1);
        apply(CMD_TEMP, 8'd0, 1'b1);
    endtask

    task automatic test_random_traffic(input int items);
        event_t ev;
        int     produced;
        for (int i = 0; i < items; i++)
        begin
            ev = random_event();
            send_event(ev, produced);
        end
    endtask

    // long receiver hold-off while changed items keep coming
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 300;
        apply(CMD_BATTERY, battery_level + 8'd1, 1'b0);
        apply(CMD_TEMP, temp_level + 8'd1, 1'b0);
        apply(CMD_FAULT, 8'd0, ~fault_lit);
        apply(CMD_BATTERY, battery_level + 8'd1, 1'b1);
    endtask

    task automatic finish_run();
        event_valid <= 1'b0;
        while (expected_bits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d items, %0d frames predicted, %0d leds checked, %0d mismatches",
                 items_sent, frames_due, bits_checked, mismatches);
        $display("directed edges, random traffic under three idling mixes, long receiver hold-off");
        if (mismatches == 0 && expected_bits.size() == 0)
        begin
            $display("led_bar_graph_serializer_unit_test OK");
        end
        else
        begin
            $display("led_bar_graph_serializer_unit_test NOT OK");
        end
        $finish;
    endtask

    initial
    begin
        for (int w = 0; w < 4; w++)
        begin
            frame_word[w] = '0;
        end
        battery_level = '0;
        temp_level    = '0;
        fault_lit     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 77;
        test_directed();
        test_random_traffic(130);

        send_idle_pct = 77;
        recv_idle_pct = 38;
        test_random_traffic(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(130);

        test_back_pressure();
        finish_run();
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lbgs_pkg.sv
rtl/core/lbgs_datapath.sv
rtl/core/lbgs_controller.sv
rtl/core/led_bar_graph_serializer_unit.sv
tb/led_bar_graph_serializer_unit_test.sv
